/* hdl/tslcd_pkg.sv */
// shared types and constants of the time-set display controller
package tslcd_pkg;

    localparam logic       ACT_START   = 1'b0;
    localparam logic       ACT_POLL    = 1'b1;

    localparam logic [1:0] ROT_NONE    = 2'd0;
    localparam logic [1:0] ROT_CW      = 2'd1;
    localparam logic [1:0] ROT_CCW     = 2'd2;

    localparam logic [1:0] STAGE_HOUR  = 2'd0;
    localparam logic [1:0] STAGE_MIN   = 2'd1;
    localparam logic [1:0] STAGE_SEC   = 2'd2;
    localparam logic [1:0] STAGE_BAD   = 2'd3;

    localparam logic       KIND_CHAR   = 1'b0;
    localparam logic       KIND_COMMIT = 1'b1;

    localparam logic [5:0] HOUR_MOD    = 6'd24;
    localparam logic [6:0] MIN_MOD     = 7'd60;
    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [5:0] MIN_MAX     = 6'd59;

    localparam logic [7:0] CHAR_EMPTY  = 8'hFF;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic       action;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [5:0] start_second;
        logic [1:0] rotary;
        logic       enter_pressed;
        logic       blink_on;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic       row;
        logic [3:0] column;
        logic [7:0] char_code;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [5:0] set_second;
    } res_t;

    typedef struct packed {
        logic capture;
        logic load_start;
        logic do_update;
        logic scan;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic session_active;
        logic scan_done;
        logic scan_stall;
        logic hold_valid;
        logic out_free;
    } status_t;

endpackage

/* hdl/tslcd_ctrl.sv */
// sequencing state machine of the time-set display controller
module tslcd_ctrl
    import tslcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    action,
    input  status_t status,
    output logic    s_tready,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && action == ACT_POLL && status.session_active)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!status.scan_stall && status.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.hold_valid || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.capture    = s_tvalid;
                cmd.load_start = s_tvalid && action == ACT_START;
            end
            ST_UPDATE:
            begin
                cmd.do_update = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/tslcd_datapath.sv */
// time registers, display rendering, shadow memory and result buffering
module tslcd_datapath
    import tslcd_pkg::*;
#(
    parameter int ROW_CHARS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmd_t     cmd,
    input  in_item_t in_item,
    input  logic     m_tready,
    output status_t  status,
    output res_t     out_res,
    output logic     out_last,
    output logic     out_valid
);

    localparam int DEPTH = 2 * ROW_CHARS;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int COL_W = $clog2(ROW_CHARS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_CHARS - 1);
    localparam logic [COL_W-1:0] TITLE_LEN = COL_W'(11);
    localparam logic [87:0] TITLE_HOUR = "SET HOUR   ";
    localparam logic [87:0] TITLE_MIN  = "SET MINUTES";
    localparam logic [87:0] TITLE_SEC  = "SET SECOND ";

    logic             session_reg;
    logic [1:0]       stage_reg;
    logic [4:0]       hour_reg;
    logic [5:0]       minute_reg;
    logic [5:0]       second_reg;
    logic [1:0]       rotary_reg;
    logic             enter_reg;
    logic             blink_reg;

    logic [7:0]       shadow_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [COL_W-1:0] col_reg;
    logic             row_reg;
    logic [IDX_W-1:0] rd_addr;

    res_t             hold_reg;
    logic             hold_valid_reg;
    res_t             out_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    logic [4:0]       hour_rot;
    logic [5:0]       minute_rot;
    logic [5:0]       second_rot;
    logic [5:0]       hour_p1;
    logic [6:0]       minute_p1;
    logic [6:0]       second_p1;
    logic             is_commit;
    logic [1:0]       stage_upd;
    logic [5:0]       minute_upd;
    logic [5:0]       second_upd;
    logic             session_upd;
    res_t             commit_res;

    logic [1:0]       stage_eff;
    logic [7:0]       cur_char;
    logic [7:0]       old_char;
    logic             diff;
    logic             out_free;
    logic             stall;
    logic             advance;
    res_t             char_res;

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] v, input logic units);
        logic [2:0] t;
        logic [5:0] u;
        t = tens_of(v);
        u = v - 6'(t) * 6'd10;
        return units ? CHAR_ZERO + {2'b00, u} : CHAR_ZERO + {5'b00000, t};
    endfunction

    // one digit position of a field: shown, blinking or not reached yet
    function automatic logic [7:0] field_char(input logic [1:0] field, input logic [1:0] stg,
                                              input logic blink, input logic [5:0] v,
                                              input logic units);
        logic [7:0] c;
        if (field < stg)
            c = digit_char(v, units);
        else if (field == stg)
            c = blink ? digit_char(v, units) : CHAR_SPACE;
        else
            c = CHAR_DASH;
        return c;
    endfunction

    // encoder step, enter handling and the commit result
    always_comb
    begin
        hour_p1    = {1'b0, hour_reg} + 6'd1;
        minute_p1  = {1'b0, minute_reg} + 7'd1;
        second_p1  = {1'b0, second_reg} + 7'd1;
        hour_rot   = hour_reg;
        minute_rot = minute_reg;
        second_rot = second_reg;
        case (rotary_reg)
            ROT_CW:
            begin
                if (stage_reg == STAGE_HOUR)
                    hour_rot = (hour_p1 >= HOUR_MOD) ? 5'(hour_p1 - HOUR_MOD) : 5'(hour_p1);
                else if (stage_reg == STAGE_MIN)
                    minute_rot = (minute_p1 >= MIN_MOD) ? 6'(minute_p1 - MIN_MOD)
                                                        : 6'(minute_p1);
                else
                    second_rot = (second_p1 >= MIN_MOD) ? 6'(second_p1 - MIN_MOD)
                                                        : 6'(second_p1);
            end
            ROT_CCW:
            begin
                if (stage_reg == STAGE_HOUR)
                    hour_rot = (hour_reg == 5'd0) ? HOUR_MAX : hour_reg - 5'd1;
                else if (stage_reg == STAGE_MIN)
                    minute_rot = (minute_reg == 6'd0) ? MIN_MAX : minute_reg - 6'd1;
                else
                    second_rot = (second_reg == 6'd0) ? MIN_MAX : second_reg - 6'd1;
            end
            default:
            begin
                hour_rot = hour_reg;
            end
        endcase

        stage_upd   = stage_reg;
        minute_upd  = minute_rot;
        second_upd  = second_rot;
        session_upd = session_reg;
        if (enter_reg)
        begin
            if (stage_reg == STAGE_HOUR)
            begin
                stage_upd  = STAGE_MIN;
                minute_upd = '0;
            end
            else if (stage_reg == STAGE_MIN)
            begin
                stage_upd  = STAGE_SEC;
                second_upd = '0;
            end
            else
            begin
                session_upd = 1'b0;
            end
        end
        is_commit = enter_reg && (stage_reg >= STAGE_SEC);

        commit_res            = '0;
        commit_res.kind       = KIND_COMMIT;
        commit_res.set_hour   = hour_rot;
        commit_res.set_minute = minute_rot;
        commit_res.set_second = second_rot;
    end

    // character at the scan position
    always_comb
    begin
        stage_eff = (stage_reg == STAGE_BAD) ? STAGE_SEC : stage_reg;
        cur_char  = CHAR_SPACE;
        if (!row_reg)
        begin
            if (col_reg < TITLE_LEN)
            begin
                case (stage_eff)
                    STAGE_HOUR: cur_char = 8'(TITLE_HOUR >> (8 * (10 - int'(col_reg))));
                    STAGE_MIN:  cur_char = 8'(TITLE_MIN  >> (8 * (10 - int'(col_reg))));
                    default:    cur_char = 8'(TITLE_SEC  >> (8 * (10 - int'(col_reg))));
                endcase
            end
        end
        else
        begin
            case (col_reg)
                COL_W'(0): cur_char = field_char(STAGE_HOUR, stage_eff, blink_reg,
                                                 {1'b0, hour_reg}, 1'b0);
                COL_W'(1): cur_char = field_char(STAGE_HOUR, stage_eff, blink_reg,
                                                 {1'b0, hour_reg}, 1'b1);
                COL_W'(2): cur_char = CHAR_COLON;
                COL_W'(3): cur_char = field_char(STAGE_MIN, stage_eff, blink_reg,
                                                 minute_reg, 1'b0);
                COL_W'(4): cur_char = field_char(STAGE_MIN, stage_eff, blink_reg,
                                                 minute_reg, 1'b1);
                COL_W'(5): cur_char = CHAR_COLON;
                COL_W'(6): cur_char = field_char(STAGE_SEC, stage_eff, blink_reg,
                                                 second_reg, 1'b0);
                COL_W'(7): cur_char = field_char(STAGE_SEC, stage_eff, blink_reg,
                                                 second_reg, 1'b1);
                default:   cur_char = CHAR_SPACE;
            endcase
        end
        old_char = valid_reg[idx_reg] ? rd_data_reg : CHAR_EMPTY;
        diff     = cur_char != old_char;
        out_free = !out_valid_reg || m_tready;
        stall    = diff && hold_valid_reg && !out_free;
        advance  = cmd.scan && !stall;
        rd_addr  = advance ? ((idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1) : idx_reg;

        char_res            = '0;
        char_res.kind       = KIND_CHAR;
        char_res.row        = row_reg;
        char_res.column     = col_reg[3:0];
        char_res.char_code  = cur_char;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rotary_reg <= in_item.rotary;
            enter_reg  <= in_item.enter_pressed;
            blink_reg  <= in_item.blink_on;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg <= 1'b0;
            stage_reg   <= STAGE_HOUR;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
        end
        else if (cmd.load_start)
        begin
            session_reg <= 1'b1;
            stage_reg   <= STAGE_HOUR;
            hour_reg    <= in_item.start_hour;
            minute_reg  <= in_item.start_minute;
            second_reg  <= in_item.start_second;
        end
        else if (cmd.do_update)
        begin
            session_reg <= session_upd;
            stage_reg   <= stage_upd;
            hour_reg    <= hour_rot;
            minute_reg  <= minute_upd;
            second_reg  <= second_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && diff)
        begin
            shadow_mem[idx_reg] <= cur_char;
        end
        rd_data_reg <= shadow_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            idx_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                valid_reg <= '0;
            end
            else if (advance && diff)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (advance)
            begin
                if (idx_reg == IDX_LAST)
                begin
                    idx_reg <= '0;
                    col_reg <= '0;
                    row_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (col_reg == COL_LAST)
                    begin
                        col_reg <= '0;
                        row_reg <= 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // one result is held back until it is known whether it is the last
    always_ff @(posedge clk)
    begin
        if (cmd.do_update && is_commit)
        begin
            hold_reg <= commit_res;
        end
        else if (advance && diff)
        begin
            hold_reg <= char_res;
        end
        if ((advance && diff && hold_valid_reg) || (cmd.flush && hold_valid_reg && out_free))
        begin
            out_reg      <= hold_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((cmd.do_update && is_commit) || (advance && diff))
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush && out_free)
            begin
                hold_valid_reg <= 1'b0;
            end
            if ((advance && diff && hold_valid_reg) || (cmd.flush && hold_valid_reg && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.session_active = session_reg;
    assign status.scan_done      = idx_reg == IDX_LAST;
    assign status.scan_stall     = stall;
    assign status.hold_valid     = hold_valid_reg;
    assign status.out_free       = out_free;

    assign out_res   = out_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    a_hold_empty_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_update |-> !hold_valid_reg)
        else $error("result buffer busy at step update");

    a_stage_legal: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg != STAGE_BAD)
        else $error("edit stage reached unused code");

    a_start_clears_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_start |=> valid_reg == '0)
        else $error("shadow not cleared by start");

    a_stall_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && stall) |=> ($stable(idx_reg) && out_valid_reg && hold_valid_reg))
        else $error("scan moved during output stall");

endmodule

/* hdl/time_set_lcd_controller.sv */
// top level of the time-set display controller
// A start transfer (tuser 0) loads hour, minute and second, opens an edit session in the
// hour stage and marks every display character for redraw; it gives no result. A poll
// transfer (tuser 1) during a session applies the encoder step, handles enter (next stage,
// or a time commit in the seconds stage, which ends the session) and then scans both display
// rows against the shadow memory, one character per cycle while output back-pressure does
// not stall the scan, sending a write for each character that changed; the commit, if any,
// comes first and tlast marks the final result of the poll. The next input is taken only
// once the scan and flush of the poll are done; a poll outside a session is dropped.
module time_set_lcd_controller
    import tslcd_pkg::*;
#(
    parameter int ROW_CHARS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_hour, start_minute, start_second, rotary, enter_pressed, blink_on, zero pad
    input  logic [23:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row, column, char_code, set_hour, set_minute, set_second, zero pad
    output logic [31:0] m_tdata,
    // kind
    output logic        m_tuser,
    output logic        m_tlast
);

    in_item_t in_item;
    cmd_t     cmd;
    status_t  status;
    res_t     out_res;
    logic     out_last;
    logic     out_valid;

    assign in_item.action        = s_tuser;
    assign in_item.start_hour    = s_tdata[4:0];
    assign in_item.start_minute  = s_tdata[10:5];
    assign in_item.start_second  = s_tdata[16:11];
    assign in_item.rotary        = s_tdata[18:17];
    assign in_item.enter_pressed = s_tdata[19];
    assign in_item.blink_on      = s_tdata[20];

    tslcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    tslcd_datapath #(
        .ROW_CHARS (ROW_CHARS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .m_tready  (m_tready),
        .status    (status),
        .out_res   (out_res),
        .out_last  (out_last),
        .out_valid (out_valid)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_last;
    assign m_tdata  = {2'b00, out_res.set_second, out_res.set_minute, out_res.set_hour,
                       out_res.char_code, out_res.column, out_res.row};

endmodule

/* dv/tb_time_set_lcd_controller.sv */
// self-checking testbench of the time-set display controller with a predicting scoreboard
`timescale 1ns / 100ps

module tb_time_set_lcd_controller
    import tslcd_pkg::*;
();

    localparam int ROW_CHARS    = 16;
    localparam int LINE_CHARS   = 2 * ROW_CHARS;
    localparam int RANDOM_ITEMS = 250;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic last;
        res_t res;
    } lcd_result_t;

    class time_edit_scoreboard;
        bit          session_on;
        logic [1:0]  stage;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [7:0]  shadow [LINE_CHARS];
        lcd_result_t lcd_expected [$];
        int          errors;
        int          starts;
        int          live_polls;
        int          dropped_polls;
        int          writes_checked;
        int          commits_checked;

        function new();
            session_on = 1'b0;
            stage      = STAGE_HOUR;
            hour       = '0;
            minute     = '0;
            second     = '0;
            foreach (shadow[i])
                shadow[i] = CHAR_EMPTY;
        endfunction

        function logic [15:0] two_digits(logic [5:0] v);
            two_digits = {8'(CHAR_ZERO + v / 10), 8'(CHAR_ZERO + v % 10)};
        endfunction

        // advances the model by one accepted transfer and queues its results
        function void predict_lcd_writes(logic act, logic [23:0] data);
            in_item_t    it;
            logic [7:0]  line [LINE_CHARS];
            lcd_result_t step_out [$];
            lcd_result_t r;
            string       title;
            logic [15:0] dg;
            it.action        = act;
            it.start_hour    = data[4:0];
            it.start_minute  = data[10:5];
            it.start_second  = data[16:11];
            it.rotary        = data[18:17];
            it.enter_pressed = data[19];
            it.blink_on      = data[20];
            if (it.action == ACT_START)
            begin
                hour       = it.start_hour;
                minute     = it.start_minute;
                second     = it.start_second;
                stage      = STAGE_HOUR;
                session_on = 1'b1;
                foreach (shadow[i])
                    shadow[i] = CHAR_EMPTY;
                starts++;
                return;
            end
            if (!session_on)
            begin
                dropped_polls++;
                return;
            end
            live_polls++;

            if (it.rotary == ROT_CW)
            begin
                if (stage == STAGE_HOUR)
                    hour = 5'((hour + 1) % HOUR_MOD);
                else if (stage == STAGE_MIN)
                    minute = 6'((minute + 1) % MIN_MOD);
                else
                    second = 6'((second + 1) % MIN_MOD);
            end
            else if (it.rotary == ROT_CCW)
            begin
                if (stage == STAGE_HOUR)
                    hour = (hour == 0) ? HOUR_MAX : hour - 5'd1;
                else if (stage == STAGE_MIN)
                    minute = (minute == 0) ? MIN_MAX : minute - 6'd1;
                else
                    second = (second == 0) ? MIN_MAX : second - 6'd1;
            end

            if (it.enter_pressed)
            begin
                if (stage == STAGE_HOUR)
                begin
                    stage  = STAGE_MIN;
                    minute = '0;
                end
                else if (stage == STAGE_MIN)
                begin
                    stage  = STAGE_SEC;
                    second = '0;
                end
                else
                begin
                    r = '0;
                    r.res.kind       = KIND_COMMIT;
                    r.res.set_hour   = hour;
                    r.res.set_minute = minute;
                    r.res.set_second = second;
                    step_out.push_back(r);
                    session_on = 1'b0;
                end
            end

            foreach (line[i])
                line[i] = CHAR_SPACE;
            if (stage == STAGE_HOUR)
                title = "SET HOUR";
            else if (stage == STAGE_MIN)
                title = "SET MINUTES";
            else
                title = "SET SECOND";
            for (int i = 0; i < title.len() && i < ROW_CHARS; i++)
                line[i] = title[i];

            line[ROW_CHARS + 2] = CHAR_COLON;
            line[ROW_CHARS + 5] = CHAR_COLON;
            if (stage != STAGE_HOUR || it.blink_on)
            begin
                dg = two_digits({1'b0, hour});
                line[ROW_CHARS]     = dg[15:8];
                line[ROW_CHARS + 1] = dg[7:0];
            end
            if (stage == STAGE_HOUR)
            begin
                line[ROW_CHARS + 3] = CHAR_DASH;
                line[ROW_CHARS + 4] = CHAR_DASH;
            end
            else if (stage == STAGE_SEC || it.blink_on)
            begin
                dg = two_digits(minute);
                line[ROW_CHARS + 3] = dg[15:8];
                line[ROW_CHARS + 4] = dg[7:0];
            end
            if (stage == STAGE_HOUR || stage == STAGE_MIN)
            begin
                line[ROW_CHARS + 6] = CHAR_DASH;
                line[ROW_CHARS + 7] = CHAR_DASH;
            end
            else if (it.blink_on)
            begin
                dg = two_digits(second);
                line[ROW_CHARS + 6] = dg[15:8];
                line[ROW_CHARS + 7] = dg[7:0];
            end

            for (int i = 0; i < LINE_CHARS; i++)
            begin
                if (line[i] != shadow[i])
                begin
                    r = '0;
                    r.res.kind      = KIND_CHAR;
                    r.res.row       = 1'((i / ROW_CHARS) & 1);
                    r.res.column    = 4'(i % ROW_CHARS);
                    r.res.char_code = line[i];
                    step_out.push_back(r);
                    shadow[i] = line[i];
                end
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                lcd_expected.push_back(step_out[i]);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_lcd_output(logic kind, logic [31:0] data, logic last);
            lcd_result_t got;
            lcd_result_t want;
            got.last           = last;
            got.res.kind       = kind;
            got.res.row        = data[0];
            got.res.column     = data[4:1];
            got.res.char_code  = data[12:5];
            got.res.set_hour   = data[17:13];
            got.res.set_minute = data[23:18];
            got.res.set_second = data[29:24];
            if (kind == KIND_COMMIT)
                commits_checked++;
            else
                writes_checked++;
            if (lcd_expected.size() == 0)
            begin
                flag($sformatf("unexpected output kind %0d row %0d col %0d char %h last %0d",
                    kind, got.res.row, got.res.column, got.res.char_code, last));
                return;
            end
            want = lcd_expected.pop_front();
            if (got !== want)
                flag($sformatf({"mismatch: exp kind %0d row %0d col %0d char %h ",
                    "time %0d:%0d:%0d last %0d, got kind %0d row %0d col %0d char %h ",
                    "time %0d:%0d:%0d last %0d"},
                    want.res.kind, want.res.row, want.res.column, want.res.char_code,
                    want.res.set_hour, want.res.set_minute, want.res.set_second, want.last,
                    got.res.kind, got.res.row, got.res.column, got.res.char_code,
                    got.res.set_hour, got.res.set_minute, got.res.set_second, got.last));
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = ACT_POLL;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int send_idle_pct = 29;
    int recv_idle_pct = 64;
    int sent_items    = 0;

    time_edit_scoreboard sb;

    time_set_lcd_controller #(
        .ROW_CHARS (ROW_CHARS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_lcd_output(m_tuser, m_tdata, m_tlast);
    end

    task automatic send_item(input logic act, input logic [23:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        sb.predict_lcd_writes(act, data);
        sent_items++;
    endtask

    task automatic send_start(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
        logic [3:0] junk;
        junk = 4'($urandom);
        send_item(ACT_START, {3'b000, junk, s, m, h});
    endtask

    task automatic send_poll(input logic [1:0] rot, input logic enter, input logic blink);
        logic [16:0] junk;
        junk = 17'($urandom);
        send_item(ACT_POLL, {3'b000, blink, enter, rot, junk});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.lcd_expected.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
        logic [1:0] rot;
        int         polls;
        int         phase;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // poll before any session is dropped
        send_poll(ROT_CW, 1'b1, 1'b1);
        // out-of-range start values, rotary code three, restart during a session
        send_start(5'd31, 6'd63, 6'd63);
        send_poll(ROT_CW, 1'b0, 1'b1);
        send_poll(2'd3, 1'b0, 1'b0);
        send_start(5'd0, 6'd0, 6'd0);
        // hour wrap both ways, then minute and second stages with wraps
        send_poll(ROT_CCW, 1'b0, 1'b1);
        send_poll(ROT_CW, 1'b0, 1'b1);
        send_poll(ROT_CW, 1'b1, 1'b1);
        send_poll(ROT_CCW, 1'b0, 1'b1);
        send_poll(ROT_CW, 1'b0, 1'b0);
        send_poll(ROT_NONE, 1'b1, 1'b1);
        send_poll(ROT_CCW, 1'b0, 1'b1);
        send_poll(ROT_CW, 1'b0, 1'b0);
        // commit, then a poll after the session has ended
        send_poll(ROT_CW, 1'b1, 1'b1);
        send_poll(ROT_CCW, 1'b1, 1'b0);
        send_start(5'd23, 6'd59, 6'd59);
        send_poll(ROT_NONE, 1'b1, 1'b0);
        send_poll(ROT_CW, 1'b1, 1'b1);
        send_poll(ROT_CCW, 1'b1, 1'b0);
        drain_results();

        sent_items = 0;
        phase      = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            if (phase == 0 && sent_items >= PHASE_ITEMS)
            begin
                drain_results();
                send_idle_pct = 64;
                recv_idle_pct = 29;
                phase = 1;
            end
            else if (phase == 1 && sent_items >= 2 * PHASE_ITEMS)
            begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                phase = 2;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    h = 5'($urandom);
                    m = 6'($urandom);
                    s = 6'($urandom);
                end
                else
                begin
                    h = 5'($urandom_range(0, 23));
                    m = 6'($urandom_range(0, 59));
                    s = 6'($urandom_range(0, 59));
                end
                send_start(h, m, s);
                polls = $urandom_range(3, 12);
                for (int i = 0; i < polls; i++)
                begin
                    rot = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                    send_poll(rot, ($urandom_range(0, 99) < 30), 1'($urandom));
                end
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                send_item(ACT_POLL, {3'b000, 21'($urandom)});
            end
            else
            begin
                send_item(ACT_START, {3'b000, 21'($urandom)});
            end
        end

        drain_results();
        repeat (LINE_CHARS + 8) @(posedge clk);
        $display("covered %0d starts, %0d polls in session and %0d dropped polls",
            sb.starts, sb.live_polls, sb.dropped_polls);
        $display("checked %0d character writes and %0d time commits, %0d errors",
            sb.writes_checked, sb.commits_checked, sb.errors);
        if (sb.errors == 0)
            $display("time_set_lcd_controller test passed");
        else
            $display("time_set_lcd_controller test failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("time_set_lcd_controller test failed");
        $finish;
    end

endmodule
